// ----- hdl/wat_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard alarm table package
// Shared constants, codes and types of the alarm table core.
// ----------------------------------------------------------------------------
`default_nettype none

package wat_pkg;

    localparam int ALARM_SLOTS_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam int FIELD_W    = 8;
    localparam int NUM_FIELDS = 5;
    localparam int PAT_W      = FIELD_W * NUM_FIELDS;
    localparam int HANDLE_W   = 4;
    localparam int SLOT_W     = 4;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    localparam logic [FIELD_W-1:0] WILDCARD = 8'hFF;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_ADDED       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REMOVED     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_PRESENT = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_MATCHED     = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NO_MATCH    = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REMOVE,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [PAT_W-1:0]    pattern;
    } t_item;

endpackage

`default_nettype wire

// ----- hdl/wat_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module wat_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/wat_match.sv -----
// ----------------------------------------------------------------------------
// Alarm pattern compare unit
// Compares one stored alarm pattern with the current time, field by field,
// where a stored field of all ones matches any value.
// ----------------------------------------------------------------------------
`default_nettype none

module wat_match (
    input  wire logic [wat_pkg::PAT_W-1:0] i_pattern,
    input  wire logic [wat_pkg::PAT_W-1:0] i_time,
    output logic                           o_hit
);
    import wat_pkg::*;

    always_comb begin
        o_hit = 1'b1;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            if (i_pattern[f*FIELD_W +: FIELD_W] != WILDCARD &&
                i_pattern[f*FIELD_W +: FIELD_W] != i_time[f*FIELD_W +: FIELD_W]) begin
                o_hit = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/wildcard_alarm_table_core.sv -----
// ----------------------------------------------------------------------------
// Wildcard alarm table core
// Alarm entries with per-field wildcards, added, removed and matched
// against the current calendar time by a small sequencer.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, kind in tuser and the time fields
// and handle in tdata. Results leave on m_axis, status in tuser, slot in
// tdata, and tlast marks the final result of each command.
// A command is taken only while the sequencer is idle. An add walks the
// valid bits one slot per cycle while the output register is free. A check
// streams the pattern RAM through the compare unit one slot per cycle while
// the receiver keeps up. At most MAX_RESULTS matches are reported, lowest
// slots first. Reset clears every valid bit at once, so the table is empty
// and usable as soon as reset is released; the pattern RAM is not cleared.
// A single output register holds each result; while the receiver stalls,
// the sequencer waits on that register and resumes when it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_alarm_table_core #(
    parameter int ALARM_SLOTS = wat_pkg::ALARM_SLOTS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // month[7:0], day[15:8], weekday[23:16], hour[31:24], minute[39:32],
    // handle[43:40], zero[47:44]
    input  wire logic [wat_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind[1:0]
    input  wire logic [wat_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // slot[3:0], zero[7:4]
    output logic      [wat_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status[2:0]
    output logic      [wat_pkg::STATUS_W-1:0]       m_axis_tuser,
    output logic                                    m_axis_tlast
);
    import wat_pkg::*;

    localparam int SW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(ALARM_SLOTS - 1);

    t_state                r_state, n_state;
    t_item                 r_item, n_item;
    logic [SW-1:0]         r_idx, n_idx;
    logic                  r_issue_done, n_issue_done;
    logic                  r_rd_vld, n_rd_vld;
    logic [SW-1:0]         r_rd_slot, n_rd_slot;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_pend_vld, n_pend_vld;
    logic [SW-1:0]         r_pend_slot, n_pend_slot;
    logic [ALARM_SLOTS-1:0] r_valid, n_valid;
    logic                  r_out_vld, n_out_vld;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [SLOT_W-1:0]     r_out_slot, n_out_slot;
    logic                  r_out_last, n_out_last;

    logic                  ram_we;
    logic                  ram_re;
    logic [PAT_W-1:0]      ram_rdata;
    logic                  pat_hit;
    logic                  cmp_hit;
    logic                  rem_hit;
    logic                  out_free;
    logic                  stall;

    wat_ram #(
        .WIDTH (PAT_W),
        .DEPTH (ALARM_SLOTS),
        .AW    (SW)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_item.pattern),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    wat_match u_match (
        .i_pattern (ram_rdata),
        .i_time    (r_item.pattern),
        .o_hit     (pat_hit)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_DATA_W - SLOT_W){1'b0}}, r_out_slot};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    assign out_free = !r_out_vld || m_axis_tready;
    assign cmp_hit  = r_rd_vld && r_valid[r_rd_slot] && pat_hit;
    assign stall    = cmp_hit && r_pend_vld && !out_free;

    always_comb begin
        rem_hit = 1'b0;
        for (int i = 0; i < ALARM_SLOTS; i++) begin
            if (32'(r_item.handle) == 32'(i)) begin
                rem_hit = r_valid[i];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_rd_vld     = r_rd_vld;
        n_rd_slot    = r_rd_slot;
        n_cnt        = r_cnt;
        n_pend_vld   = r_pend_vld;
        n_pend_slot  = r_pend_slot;
        n_valid      = r_valid;
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_item.kind    = s_axis_tuser;
                    n_item.pattern = s_axis_tdata[PAT_W-1:0];
                    n_item.handle  = s_axis_tdata[PAT_W +: HANDLE_W];
                    n_idx          = '0;
                    n_issue_done   = 1'b0;
                    n_rd_vld       = 1'b0;
                    n_cnt          = '0;
                    n_pend_vld     = 1'b0;
                    case (s_axis_tuser)
                        KIND_ADD:    n_state = S_ADD;
                        KIND_REMOVE: n_state = S_REMOVE;
                        KIND_CHECK:  n_state = S_CHECK;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if (out_free) begin
                    if (!r_valid[r_idx]) begin
                        ram_we           = 1'b1;
                        n_valid[r_idx]   = 1'b1;
                        n_out_vld        = 1'b1;
                        n_out_status     = STAT_ADDED;
                        n_out_slot       = SLOT_W'(r_idx);
                        n_out_last       = 1'b1;
                        n_state          = S_IDLE;
                    end else if (r_idx == SLOT_LAST) begin
                        n_out_vld        = 1'b1;
                        n_out_status     = STAT_FULL;
                        n_out_slot       = '0;
                        n_out_last       = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_REMOVE: begin
                if (out_free) begin
                    for (int i = 0; i < ALARM_SLOTS; i++) begin
                        if (32'(r_item.handle) == 32'(i)) begin
                            n_valid[i] = 1'b0;
                        end
                    end
                    n_out_vld    = 1'b1;
                    n_out_status = rem_hit ? STAT_REMOVED : STAT_NOT_PRESENT;
                    n_out_slot   = r_item.handle;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_CHECK: begin
                if (!stall) begin
                    if (!r_issue_done) begin
                        ram_re    = 1'b1;
                        n_rd_vld  = 1'b1;
                        n_rd_slot = r_idx;
                        if (r_idx == SLOT_LAST) begin
                            n_issue_done = 1'b1;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end else begin
                        n_rd_vld = 1'b0;
                    end
                    if (cmp_hit) begin
                        if (r_pend_vld) begin
                            n_out_vld    = 1'b1;
                            n_out_status = STAT_MATCHED;
                            n_out_slot   = SLOT_W'(r_pend_slot);
                            n_out_last   = 1'b0;
                        end
                        n_pend_vld  = 1'b1;
                        n_pend_slot = r_rd_slot;
                        n_cnt       = r_cnt + 1'b1;
                    end
                    if ((cmp_hit && r_cnt == CNT_W'(MAX_RESULTS - 1)) ||
                        (r_rd_vld && r_rd_slot == SLOT_LAST)) begin
                        n_state  = S_FINISH;
                        n_rd_vld = 1'b0;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_last = 1'b1;
                    if (r_pend_vld) begin
                        n_out_status = STAT_MATCHED;
                        n_out_slot   = SLOT_W'(r_pend_slot);
                    end else begin
                        n_out_status = STAT_NO_MATCH;
                        n_out_slot   = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_cnt        <= '0;
            r_pend_vld   <= 1'b0;
            r_valid      <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= n_rd_vld;
            r_cnt        <= n_cnt;
            r_pend_vld   <= n_pend_vld;
            r_valid      <= n_valid;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_idx        <= n_idx;
        r_rd_slot    <= n_rd_slot;
        r_pend_slot  <= n_pend_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_last   <= n_out_last;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("match count exceeds the result limit");

    a_mid_is_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |-> (r_out_status == STAT_MATCHED))
        else $error("non-final result is not a match");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready &&
         (s_axis_tuser == KIND_ADD || s_axis_tuser == KIND_REMOVE ||
          s_axis_tuser == KIND_CHECK)) |=> !s_axis_tready)
        else $error("valid command did not start the sequencer");

    a_pend_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_vld && (r_state == S_CHECK || r_state == S_FINISH)) |->
        r_valid[r_pend_slot])
        else $error("pending match refers to a free slot");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// Wildcard alarm table testbench
// Drives add, remove and time check commands into the alarm table core and
// compares every result transfer with an in-bench prediction of the table.
// The run starts with a short directed sequence that fills the table and then
// tries one add too many. Random commands follow, biased in turn toward adds and toward checks.
// The sender works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wat_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam int RANDOM_COMMANDS = 430;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 2 * TABLE_SLOTS + 8;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } t_alarm_result;

    class alarm_table_scoreboard;
        bit                armed[TABLE_SLOTS];
        logic [PAT_W-1:0]  entry[TABLE_SLOTS];
        t_alarm_result     due_results[$];
        int                errors;
        int                commands;
        int                checks;
        int                status_seen[8];

        function new();
            errors = 0;
            commands = 0;
            checks = 0;
            foreach (armed[i]) armed[i] = 1'b0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void push_result(logic [STATUS_W-1:0] status, int slot, bit last);
            t_alarm_result res;
            res.status = status;
            res.slot = SLOT_W'(slot);
            res.last = last;
            due_results.push_back(res);
        endfunction

        function void note_command(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] data);
            logic [PAT_W-1:0]    now;
            logic [HANDLE_W-1:0] handle;
            logic [FIELD_W-1:0]  stored;
            int                  hits[$];
            int                  free_slot;
            bit                  hit;
            now = data[PAT_W-1:0];
            handle = data[PAT_W +: HANDLE_W];
            free_slot = -1;
            if (kind != KIND_RESERVED) commands++;
            case (kind)
                KIND_ADD: begin
                    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
                        if (!armed[i]) free_slot = i;
                    end
                    if (free_slot < 0) begin
                        push_result(STAT_FULL, 0, 1'b1);
                    end else begin
                        armed[free_slot] = 1'b1;
                        entry[free_slot] = now;
                        push_result(STAT_ADDED, free_slot, 1'b1);
                    end
                end
                KIND_REMOVE: begin
                    if (int'(handle) < TABLE_SLOTS && armed[handle]) begin
                        armed[handle] = 1'b0;
                        push_result(STAT_REMOVED, int'(handle), 1'b1);
                    end else begin
                        push_result(STAT_NOT_PRESENT, int'(handle), 1'b1);
                    end
                end
                KIND_CHECK: begin
                    checks++;
                    for (int i = 0; i < TABLE_SLOTS && hits.size() < MAX_RESULTS; i++) begin
                        hit = armed[i];
                        for (int j = 0; j < NUM_FIELDS; j++) begin
                            stored = entry[i][FIELD_W*j +: FIELD_W];
                            if (hit && stored != WILDCARD && stored != now[FIELD_W*j +: FIELD_W])
                                hit = 1'b0;
                        end
                        if (hit) hits.push_back(i);
                    end
                    if (hits.size() == 0) begin
                        push_result(STAT_NO_MATCH, 0, 1'b1);
                    end else begin
                        foreach (hits[k])
                            push_result(STAT_MATCHED, hits[k], k == hits.size() - 1);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [OUT_DATA_W-1:0] data,
                                   logic last);
            t_alarm_result want;
            logic [OUT_DATA_W-1:0] want_data;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result transfer, status %0d data 0x%0h last %0b",
                         $time, status, data, last);
                errors++;
                return;
            end
            want = due_results.pop_front();
            want_data = OUT_DATA_W'(want.slot);
            if (status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, status);
                errors++;
            end
            if (data !== want_data) begin
                $display("%0t: slot mismatch, expected 0x%0h, actual 0x%0h",
                         $time, want_data, data);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last flag mismatch, expected %0b, actual %0b",
                         $time, want.last, last);
                errors++;
            end
            status_seen[want.status]++;
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic [KIND_W-1:0]     s_kind = '0;
    logic                  m_ready = 1'b0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  m_axis_tlast;

    alarm_table_scoreboard sb = new();

    bit valid_up = 1'b0;
    int burst_left = 4;
    int sent = 0;
    int cycles = 0;
    int rx_tick = 0;
    int rx_left = 0;
    int rx_mode = 0;
    int rx_period = 1;
    int rx_duty = 0;

    wildcard_alarm_table_core #(
        .ALARM_SLOTS(TABLE_SLOTS)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_kind),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d results outstanding",
                     $time, sb.due_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: fully ready, periodic stalls or random stalls, re-chosen often.
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_ready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_period = $urandom_range(2, 16);
            rx_duty = $urandom_range(1, rx_period - 1);
            rx_left = $urandom_range(40, 300);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= (rx_tick % rx_period) >= rx_duty;
            default: m_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    function automatic logic [IN_DATA_W-1:0] command_word(
        int month, int day, int weekday, int hour, int minute, int handle);
        return {4'h0, HANDLE_W'(handle), FIELD_W'(minute), FIELD_W'(hour),
                FIELD_W'(weekday), FIELD_W'(day), FIELD_W'(month)};
    endfunction

    task automatic send_command(input logic [KIND_W-1:0] kind, input logic [IN_DATA_W-1:0] data);
        int gap;
        s_valid <= 1'b1;
        s_kind <= kind;
        s_data <= data;
        valid_up = 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_command(kind, data);
        if (kind != KIND_RESERVED) sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                valid_up = 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic wait_drained();
        if (valid_up) begin
            s_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (sb.due_results.size() != 0) @(posedge clk);
    endtask

    function automatic int alarm_field();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return int'(WILDCARD);
        if (p < 85) return $urandom_range(0, 1);
        return $urandom_range(0, 255);
    endfunction

    function automatic int time_field();
        return ($urandom_range(0, 99) < 80) ? $urandom_range(0, 1) : $urandom_range(0, 255);
    endfunction

    function automatic int removal_handle();
        int used[$];
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (sb.armed[i]) used.push_back(i);
        end
        if (used.size() == 0 || $urandom_range(0, 9) < 3) return $urandom_range(0, 15);
        return used[$urandom_range(0, used.size() - 1)];
    endfunction

    task automatic run_directed();
        int wild;
        wild = int'(WILDCARD);
        send_command(KIND_CHECK, command_word(0, 0, 0, 0, 0, 0));
        send_command(KIND_REMOVE, command_word(0, 0, 0, 0, 0, 0));
        send_command(KIND_ADD, command_word(wild, wild, wild, wild, wild, 0));
        send_command(KIND_ADD, command_word(0, 0, 0, 0, 0, 0));
        send_command(KIND_ADD, command_word(12, 31, 6, 23, 59, 0));
        send_command(KIND_CHECK, command_word(wild, wild, wild, wild, wild, 0));
        send_command(KIND_CHECK, command_word(0, 0, 0, 0, 0, 0));
        send_command(KIND_RESERVED, {4'h0, {44{1'b1}}});
        send_command(KIND_REMOVE, command_word(0, 0, 0, 0, 0, 1));
        send_command(KIND_REMOVE, command_word(0, 0, 0, 0, 0, 1));
        send_command(KIND_REMOVE, command_word(0, 0, 0, 0, 0, 15));
        repeat (TABLE_SLOTS - 2)
            send_command(KIND_ADD, command_word(wild, wild, wild, wild, wild, 0));
        send_command(KIND_ADD, command_word(1, 1, 1, 1, 1, 0));
        send_command(KIND_CHECK, command_word(12, 31, 6, 23, 59, 0));
    endtask

    task automatic run_random();
        int r;
        int add_share;
        int goal;
        goal = sent + RANDOM_COMMANDS;
        while (sent < goal) begin
            if (sent == goal - RANDOM_COMMANDS / 2) wait_drained();
            add_share = ((sent / 50) % 2 == 0) ? 50 : 20;
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_command(KIND_RESERVED, {4'h0, 12'($urandom), 32'($urandom)});
            end else if (r < 4 + add_share) begin
                send_command(KIND_ADD, command_word(alarm_field(), alarm_field(), alarm_field(),
                                                    alarm_field(), alarm_field(),
                                                    $urandom_range(0, 15)));
            end else if (r < 34 + add_share) begin
                send_command(KIND_REMOVE, command_word($urandom_range(0, 255),
                                                       $urandom_range(0, 255),
                                                       $urandom_range(0, 255),
                                                       $urandom_range(0, 255),
                                                       $urandom_range(0, 255),
                                                       removal_handle()));
            end else begin
                send_command(KIND_CHECK, command_word(time_field(), time_field(), time_field(),
                                                      time_field(), time_field(),
                                                      $urandom_range(0, 15)));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        run_random();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d commands: %0d adds (%0d on a full table), %0d removes %s",
                 sb.commands, sb.status_seen[STAT_ADDED] + sb.status_seen[STAT_FULL],
                 sb.status_seen[STAT_FULL],
                 sb.status_seen[STAT_REMOVED] + sb.status_seen[STAT_NOT_PRESENT],
                 $sformatf("(%0d of free slots).", sb.status_seen[STAT_NOT_PRESENT]));
        $display("%0d time checks gave %0d alarm matches and %0d empty answers.",
                 sb.checks, sb.status_seen[STAT_MATCHED], sb.status_seen[STAT_NO_MATCH]);
        if (sb.due_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.due_results.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
